FILE: rtl/ted_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ted_pkg
// Shared types and codes for the tracker event word deframer.
// ----------------------------------------------------------------------------
package ted_pkg;

    localparam int WORD_W = 32;

    localparam logic [1:0] REG_BLOCK_CHECK_BIT = 2'd0;
    localparam logic [1:0] REG_MAX_WIRE_HITS   = 2'd1;
    localparam logic [1:0] REG_MAX_SCINT_HITS  = 2'd2;

    localparam logic [3:0] TYPE_WIRE  = 4'd0;
    localparam logic [3:0] TYPE_SCINT = 4'd7;
    localparam logic [3:0] TYPE_EVENT = 4'd8;
    localparam logic [3:0] TYPE_EOF   = 4'd15;

    localparam logic [3:0] KIND_EVENT_ID    = 4'd0;
    localparam logic [3:0] KIND_EVENT_HDR   = 4'd1;
    localparam logic [3:0] KIND_WIRE        = 4'd2;
    localparam logic [3:0] KIND_SCINT       = 4'd3;
    localparam logic [3:0] KIND_BLOCK_DATE  = 4'd4;
    localparam logic [3:0] KIND_BLOCK_TIME  = 4'd5;
    localparam logic [3:0] KIND_STRAY_SCINT = 4'd6;
    localparam logic [3:0] KIND_STRAY_WIRE  = 4'd7;
    localparam logic [3:0] KIND_EOF         = 4'd8;
    localparam logic [3:0] KIND_TYPE_ERROR  = 4'd9;
    localparam logic [3:0] KIND_COUNT_ERROR = 4'd10;
    localparam logic [3:0] KIND_HALTED      = 4'd11;

    localparam logic [7:0]  BLOCK_CHECK_BIT_RST = 8'd23;
    localparam logic [7:0]  MAX_WIRE_HITS_RST   = 8'd96;
    localparam logic [3:0]  MAX_SCINT_HITS_RST  = 4'd8;
    localparam logic [23:0] EVENTS_MAX          = 24'hFFFFFF;
    localparam logic [15:0] BLOCKS_MAX          = 16'hFFFF;

    typedef enum logic [2:0] {
        CL_WIRE,
        CL_SCINT,
        CL_EVENT,
        CL_EOF,
        CL_OTHER
    } cls_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EVHDR,
        PH_WIRES,
        PH_SCINTS,
        PH_BLKTIME,
        PH_HALT
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        cls_t              cls;
        logic              blk_bit;
    } item_t;

    typedef struct packed {
        logic [7:0] max_wire_hits;
        logic [3:0] max_scint_hits;
    } limits_t;

    typedef struct packed {
        logic [3:0]  word_kind;
        logic [6:0]  hit_channel;
        logic [15:0] hit_time;
        logic [7:0]  hit_slot;
        logic [15:0] event_number;
        logic [11:0] block_number;
        logic [7:0]  wire_total;
        logic [3:0]  scint_total;
        logic        event_complete;
        logic [23:0] events_read;
        logic [23:0] events_expected;
        logic [15:0] blocks_seen;
    } res_t;

endpackage
`default_nettype wire

FILE: rtl/ted_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ted_front
// Accept words, classify the entry type and queue them for the back end.
// ----------------------------------------------------------------------------
module ted_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [31:0]   data_word,
    input  wire logic [4:0]    block_check_bit,
    output logic               head_valid,
    output ted_pkg::item_t     head,
    input  wire logic          head_take
);
    import ted_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    item_t       in_item;
    logic        do_push;
    logic        do_pop;

    always_comb
    begin
        in_item.word    = data_word;
        in_item.blk_bit = data_word[block_check_bit];
        unique case (data_word[31:28])
            TYPE_WIRE:  in_item.cls = CL_WIRE;
            TYPE_SCINT: in_item.cls = CL_SCINT;
            TYPE_EVENT: in_item.cls = CL_EVENT;
            TYPE_EOF:   in_item.cls = CL_EOF;
            default:    in_item.cls = CL_OTHER;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_take && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ted_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ted_back
// Follow the event and block framing and queue one result per word.
// ----------------------------------------------------------------------------
module ted_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire ted_pkg::item_t  item,
    output logic                 item_take,
    input  wire ted_pkg::limits_t limits,
    output logic                 empty,
    input  wire logic            pop,
    output ted_pkg::res_t        res
);
    import ted_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  wires_left_reg, wires_left_next;
    logic [3:0]  scints_left_reg, scints_left_next;
    logic [7:0]  slot_reg, slot_next;
    logic [15:0] cur_event_reg, cur_event_next;
    logic [11:0] cur_block_reg, cur_block_next;
    logic [7:0]  wire_count_reg, wire_count_next;
    logic [3:0]  scint_count_reg, scint_count_next;
    logic [23:0] good_events_reg, good_events_next;
    logic [15:0] block_counter_reg, block_counter_next;
    logic [7:0]  wires_dec;
    logic [3:0]  scints_dec;
    logic [31:0] w;
    res_t        r;

    res_t        mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        out_full;
    logic        do_pop;

    assign out_full   = (count_reg == 2'd2);
    assign item_take  = item_valid && !out_full;
    assign do_pop     = pop && !empty;
    assign empty      = (count_reg == 2'd0);
    assign res        = mem_reg[rd_ptr_reg];
    assign w          = item.word;
    assign wires_dec  = wires_left_reg - 8'd1;
    assign scints_dec = scints_left_reg - 4'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        wires_left_next    = wires_left_reg;
        scints_left_next   = scints_left_reg;
        slot_next          = slot_reg;
        cur_event_next     = cur_event_reg;
        cur_block_next     = cur_block_reg;
        wire_count_next    = wire_count_reg;
        scint_count_next   = scint_count_reg;
        good_events_next   = good_events_reg;
        block_counter_next = block_counter_reg;
        r                  = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                case (item.cls)
                    CL_EVENT:
                    begin
                        cur_event_next = w[15:0];
                        cur_block_next = w[27:16];
                        phase_next     = PH_EVHDR;
                        r.word_kind    = KIND_EVENT_ID;
                    end
                    CL_EOF:
                    begin
                        r.events_expected = w[23:0];
                        phase_next        = PH_HALT;
                        r.word_kind       = KIND_EOF;
                    end
                    CL_SCINT:
                    begin
                        r.word_kind   = KIND_STRAY_SCINT;
                        r.hit_channel = {4'd0, w[18:16]};
                        r.hit_time    = w[15:0];
                    end
                    default:
                    begin
                        if (!item.blk_bit)
                        begin
                            r.word_kind   = KIND_STRAY_WIRE;
                            r.hit_channel = w[22:16];
                            r.hit_time    = w[15:0];
                        end
                        else
                        begin
                            phase_next  = PH_BLKTIME;
                            r.word_kind = KIND_BLOCK_DATE;
                        end
                    end
                endcase
            end
            PH_BLKTIME:
            begin
                if (block_counter_reg != BLOCKS_MAX)
                begin
                    block_counter_next = block_counter_reg + 16'd1;
                end
                phase_next  = PH_IDLE;
                r.word_kind = KIND_BLOCK_TIME;
            end
            PH_EVHDR:
            begin
                wire_count_next  = w[23:16];
                scint_count_next = w[27:24];
                if (item.cls != CL_EVENT)
                begin
                    phase_next  = PH_HALT;
                    r.word_kind = KIND_TYPE_ERROR;
                end
                else if (w[23:16] > limits.max_wire_hits
                         || w[27:24] > limits.max_scint_hits)
                begin
                    phase_next  = PH_HALT;
                    r.word_kind = KIND_COUNT_ERROR;
                end
                else
                begin
                    r.word_kind      = KIND_EVENT_HDR;
                    wires_left_next  = w[23:16];
                    scints_left_next = w[27:24];
                    slot_next        = 8'd0;
                    if (w[23:16] != 8'd0)
                    begin
                        phase_next = PH_WIRES;
                    end
                    else if (w[27:24] != 4'd0)
                    begin
                        phase_next = PH_SCINTS;
                    end
                    else
                    begin
                        r.event_complete = 1'b1;
                        phase_next       = PH_IDLE;
                        if (good_events_reg != EVENTS_MAX)
                        begin
                            good_events_next = good_events_reg + 24'd1;
                        end
                    end
                end
            end
            PH_WIRES:
            begin
                if (item.cls != CL_WIRE)
                begin
                    phase_next  = PH_HALT;
                    r.word_kind = KIND_TYPE_ERROR;
                end
                else
                begin
                    r.word_kind     = KIND_WIRE;
                    r.hit_channel   = w[22:16];
                    r.hit_time      = w[15:0];
                    r.hit_slot      = slot_reg;
                    slot_next       = slot_reg + 8'd1;
                    wires_left_next = wires_dec;
                    if (wires_dec == 8'd0)
                    begin
                        slot_next = 8'd0;
                        if (scints_left_reg != 4'd0)
                        begin
                            phase_next = PH_SCINTS;
                        end
                        else
                        begin
                            r.event_complete = 1'b1;
                            phase_next       = PH_IDLE;
                            if (good_events_reg != EVENTS_MAX)
                            begin
                                good_events_next = good_events_reg + 24'd1;
                            end
                        end
                    end
                end
            end
            PH_SCINTS:
            begin
                if (item.cls != CL_SCINT)
                begin
                    phase_next  = PH_HALT;
                    r.word_kind = KIND_TYPE_ERROR;
                end
                else
                begin
                    r.word_kind      = KIND_SCINT;
                    r.hit_channel    = {4'd0, w[18:16]};
                    r.hit_time       = w[15:0];
                    r.hit_slot       = slot_reg;
                    slot_next        = slot_reg + 8'd1;
                    scints_left_next = scints_dec;
                    if (scints_dec == 4'd0)
                    begin
                        slot_next        = 8'd0;
                        r.event_complete = 1'b1;
                        phase_next       = PH_IDLE;
                        if (good_events_reg != EVENTS_MAX)
                        begin
                            good_events_next = good_events_reg + 24'd1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next  = PH_HALT;
                r.word_kind = KIND_HALTED;
            end
        endcase

        r.event_number = cur_event_next;
        r.block_number = cur_block_next;
        r.wire_total   = wire_count_next;
        r.scint_total  = scint_count_next;
        r.events_read  = good_events_next;
        r.blocks_seen  = block_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            wires_left_reg    <= 8'd0;
            scints_left_reg   <= 4'd0;
            slot_reg          <= 8'd0;
            cur_event_reg     <= 16'd0;
            cur_block_reg     <= 12'd0;
            wire_count_reg    <= 8'd0;
            scint_count_reg   <= 4'd0;
            good_events_reg   <= 24'd0;
            block_counter_reg <= 16'd0;
        end
        else if (item_take)
        begin
            phase_reg         <= phase_next;
            wires_left_reg    <= wires_left_next;
            scints_left_reg   <= scints_left_next;
            slot_reg          <= slot_next;
            cur_event_reg     <= cur_event_next;
            cur_block_reg     <= cur_block_next;
            wire_count_reg    <= wire_count_next;
            scint_count_reg   <= scint_count_next;
            good_events_reg   <= good_events_next;
            block_counter_reg <= block_counter_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (item_take && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !item_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (item_take)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            mem_reg[wr_ptr_reg] <= r;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tracker_event_word_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tracker_event_word_deframer
// Decode a stream of 32-bit tracker readout words into one result per word.
//
// Input side: a word transfers on a clock edge with push high and full low.
// Result side: while empty is low the oldest result sits on the result ports;
// it transfers on a clock edge with pop high.
// Configuration: wr_en writes wr_data to the register chosen by wr_index on
// the same edge; write only while no word is in flight.
// The classifier tags each word as it enters the input queue; the framing
// state machine decodes the word at the head of that queue and writes its
// result into the result queue, which drives the result ports.
// Throughput: one word per cycle while the result queue has room; two-entry
// queues on both sides keep that rate with registered full and empty flags.
// When pop stays low the result queue fills, the state machine holds, and
// then the input queue fills and raises full. No word or result is dropped.
// Reset clears both queues, the framing state and all counters, and loads
// the register defaults. After an end-of-file word or an error every word
// gives a halted result until reset.
// ----------------------------------------------------------------------------
module tracker_event_word_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] data_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       word_kind,
    output logic [6:0]       hit_channel,
    output logic [15:0]      hit_time,
    output logic [7:0]       hit_slot,
    output logic [15:0]      event_number,
    output logic [11:0]      block_number,
    output logic [7:0]       wire_total,
    output logic [3:0]       scint_total,
    output logic             event_complete,
    output logic [23:0]      events_read,
    output logic [23:0]      events_expected,
    output logic [15:0]      blocks_seen,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [7:0]  wr_data
);
    import ted_pkg::*;

    logic [4:0] block_check_bit_reg;
    limits_t    limits_reg;
    logic       head_valid;
    item_t      head;
    logic       head_take;
    res_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_check_bit_reg       <= BLOCK_CHECK_BIT_RST[4:0];
            limits_reg.max_wire_hits  <= MAX_WIRE_HITS_RST;
            limits_reg.max_scint_hits <= MAX_SCINT_HITS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BLOCK_CHECK_BIT: block_check_bit_reg       <= wr_data[4:0];
                REG_MAX_WIRE_HITS:   limits_reg.max_wire_hits  <= wr_data;
                REG_MAX_SCINT_HITS:  limits_reg.max_scint_hits <= wr_data[3:0];
                default:             ;
            endcase
        end
    end

    ted_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_word       (data_word),
        .block_check_bit (block_check_bit_reg),
        .head_valid      (head_valid),
        .head            (head),
        .head_take       (head_take)
    );

    ted_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (head_valid),
        .item       (head),
        .item_take  (head_take),
        .limits     (limits_reg),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign word_kind       = res.word_kind;
    assign hit_channel     = res.hit_channel;
    assign hit_time        = res.hit_time;
    assign hit_slot        = res.hit_slot;
    assign event_number    = res.event_number;
    assign block_number    = res.block_number;
    assign wire_total      = res.wire_total;
    assign scint_total     = res.scint_total;
    assign event_complete  = res.event_complete;
    assign events_read     = res.events_read;
    assign events_expected = res.events_expected;
    assign blocks_seen     = res.blocks_seen;

    a_slot_only_on_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && word_kind != KIND_WIRE && word_kind != KIND_SCINT) |-> hit_slot == 8'd0)
        else $error("hit slot set on a non-hit result");

    a_complete_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_complete) |->
            (word_kind == KIND_EVENT_HDR || word_kind == KIND_WIRE
             || word_kind == KIND_SCINT))
        else $error("event completed by a word that cannot end an event");

    a_expected_only_on_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && word_kind != KIND_EOF) |-> events_expected == 24'd0)
        else $error("event total reported outside an end-of-file result");

    a_complete_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_complete) |-> events_read != 24'd0)
        else $error("completed event not counted");

endmodule
`default_nettype wire
